// ----- hw/rtl/ncpr_pkg.sv -----
// Shared types, codes and helpers for the n-chance clock page replacer.
package ncpr_pkg;

    // Per-slot replacement state kept in the metadata RAM.
    typedef struct packed {
        logic [7:0] cnt;
        logic       used;
        logic       dirty;
    } t_meta;

    localparam logic [1:0] ACT_ACCESS  = 2'd0;
    localparam logic [1:0] ACT_PLACE   = 2'd1;
    localparam logic [1:0] ACT_REPLACE = 2'd2;
    localparam logic [1:0] ACT_INVALID = 2'd3;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_FAULT  = 1'b1;

    localparam logic REG_SWEEP_LIMIT = 1'b0;
    localparam logic REG_SET_LIMIT   = 1'b1;

    localparam logic [7:0] SWEEP_LIMIT_RST = 8'd1;
    localparam logic [5:0] SET_LIMIT_RST   = 6'd32;

    localparam logic [7:0] CNT_MAX  = 8'hFF;
    localparam logic [7:0] GAP_NONE = 8'hFF;

    localparam int SLOT_FIELD_BITS = 5;

    // Eviction threshold; a negative setting gives dirty pages one more sweep.
    function automatic logic [7:0] sweep_lim_for(input logic [7:0] raw, input logic dirty);
        logic [7:0] lim;
        if (raw[7]) begin
            lim = (8'd0 - raw) + {7'd0, dirty};
        end else begin
            lim = raw;
        end
        return lim;
    endfunction

endpackage

// ----- hw/rtl/ncpr_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port (read-first).
module ncpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/nchance_clock_page_replacer_core.sv -----
// N-chance clock page replacer: item sequencer, sweep datapath and APB registers.
// One item at a time. An access updates its slot in S_ACC; placement or an invalid slot go
// straight to S_DONE; a replacement sweeps in S_SWEEP, where the hand visits 1 to 2 x
// resident slots, then reads the victim page in S_EVICT; the metadata RAM read port sets the
// sweep pace of one slot a cycle. A new item is taken while a result waits.
// Reset (synchronous) clears fill count, hand, registers and control; the RAMs get no clearing
// pass, as every slot is written by its placement before it is ever read.
module nchance_clock_page_replacer_core
    import ncpr_pkg::*;
#(
    parameter int SET_SLOTS = 32,
    parameter int PAGE_BITS = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // stream in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [PAGE_BITS-1:0] page_number, then slot_index (5), is_write (1), zero pad
    input  logic [((PAGE_BITS+13)/8)*8-1:0]     s_tdata,
    // [0] opcode
    input  logic                                s_tuser,
    // stream out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [4:0] chosen_slot, then evicted_page (PAGE_BITS), needs_writeback (1), zero pad
    output logic [((PAGE_BITS+13)/8)*8-1:0]     m_tdata,
    // [1:0] action
    output logic [1:0]                          m_tuser,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int SW = $clog2(SET_SLOTS);
    localparam int FW = $clog2(SET_SLOTS + 1);
    localparam int DW = ((PAGE_BITS + 13) / 8) * 8;
    localparam int MW = $bits(t_meta);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACC   = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_EVICT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // ---------------- configuration ----------------
    logic [7:0] r_sweep_lim;
    logic [5:0] r_set_lim;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_lim <= SWEEP_LIMIT_RST;
            r_set_lim   <= SET_LIMIT_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_SWEEP_LIMIT: r_sweep_lim <= pwdata[7:0];
                REG_SET_LIMIT:   r_set_lim   <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SWEEP_LIMIT: prdata = {24'd0, r_sweep_lim};
            REG_SET_LIMIT:   prdata = {26'd0, r_set_lim};
            default:         prdata = '0;
        endcase
    end

    logic [FW-1:0] eff_set_lim;
    always_comb begin
        if (r_set_lim == 6'd0) begin
            eff_set_lim = FW'(1);
        end else if (int'(r_set_lim) > SET_SLOTS) begin
            eff_set_lim = FW'(SET_SLOTS);
        end else begin
            eff_set_lim = FW'(r_set_lim);
        end
    end

    // ---------------- state ----------------
    logic [2:0]           r_state;
    logic [FW-1:0]        r_fill;
    logic [SW-1:0]        r_hand;
    logic [SW-1:0]        r_cur;
    logic [FW-1:0]        r_step;
    logic                 r_pass;
    logic [7:0]           r_incr;
    logic [7:0]           r_gap;
    logic                 r_fwd;
    t_meta                r_fwd_meta;
    logic [PAGE_BITS-1:0] r_page;
    logic                 r_wr;
    logic [4:0]           r_slot;

    logic [1:0]           r_res_act;
    logic [4:0]           r_res_slot;
    logic [PAGE_BITS-1:0] r_res_page;
    logic                 r_res_wb;

    logic                 r_m_valid;
    logic [1:0]           r_m_act;
    logic [4:0]           r_m_slot;
    logic [PAGE_BITS-1:0] r_m_page;
    logic                 r_m_wb;

    // ---------------- input decode ----------------
    logic                 in_acc;
    logic [PAGE_BITS-1:0] in_page;
    logic [4:0]           in_slot;
    logic                 in_wr;
    logic                 slot_ok;
    logic                 can_place;
    logic [SW-1:0]        start_hand;

    assign s_tready   = (r_state == S_IDLE);
    assign in_acc     = s_tvalid && s_tready;
    assign in_page    = s_tdata[PAGE_BITS-1:0];
    assign in_slot    = s_tdata[PAGE_BITS +: SLOT_FIELD_BITS];
    assign in_wr      = s_tdata[PAGE_BITS + SLOT_FIELD_BITS];
    assign slot_ok    = (32'(in_slot) < 32'(r_fill));
    assign can_place  = (r_fill < eff_set_lim);
    assign start_hand = (FW'(r_hand) >= r_fill) ? '0 : r_hand;

    // ---------------- memories ----------------
    logic                 meta_we;
    logic [SW-1:0]        meta_waddr;
    t_meta                meta_wdata;
    logic [SW-1:0]        meta_raddr;
    logic [MW-1:0]        meta_rdata;
    logic                 page_we;
    logic [SW-1:0]        page_waddr;
    logic [PAGE_BITS-1:0] page_wdata;
    logic [PAGE_BITS-1:0] page_rdata;

    ncpr_ram #(.WIDTH(MW), .DEPTH(SET_SLOTS)) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_raddr (meta_raddr),
        .o_rdata (meta_rdata)
    );

    // page write and victim read share a cycle; read-first returns the outgoing page
    ncpr_ram #(.WIDTH(PAGE_BITS), .DEPTH(SET_SLOTS)) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (page_we),
        .i_waddr (page_waddr),
        .i_wdata (page_wdata),
        .i_raddr (r_cur),
        .o_rdata (page_rdata)
    );

    // ---------------- sweep datapath ----------------
    t_meta         meta_cur;
    logic [7:0]    lim;
    logic [8:0]    cnt_sum;
    logic [7:0]    cnt_new;
    logic [7:0]    gap;
    logic [7:0]    gap_min;
    logic          last_step;
    logic          sw_hit;
    logic [FW-1:0] cur_inc;
    logic [SW-1:0] next_slot;
    t_meta         sweep_meta;

    // a one-slot ring rereads the entry just written, so take it from the bypass
    assign meta_cur  = r_fwd ? r_fwd_meta : t_meta'(meta_rdata);
    assign lim       = sweep_lim_for(r_sweep_lim, meta_cur.dirty);
    assign cnt_sum   = {1'b0, meta_cur.cnt} + {1'b0, r_incr};
    assign cnt_new   = meta_cur.used ? 8'd0 : (cnt_sum[8] ? CNT_MAX : cnt_sum[7:0]);
    assign gap       = lim - cnt_new;
    assign gap_min   = (gap < r_gap) ? gap : r_gap;
    assign last_step = (r_step == r_fill - FW'(1));
    // second pass always ends on a victim; its last slot is taken as one for safety
    assign sw_hit    = (cnt_new >= lim) || (r_pass && last_step);
    assign cur_inc   = FW'(r_cur) + FW'(1);
    assign next_slot = (cur_inc >= r_fill) ? '0 : SW'(cur_inc);

    always_comb begin
        sweep_meta.cnt   = cnt_new;
        sweep_meta.used  = 1'b0;
        sweep_meta.dirty = meta_cur.dirty;
    end

    always_comb begin
        meta_we    = 1'b0;
        meta_waddr = r_cur;
        meta_wdata = '0;
        meta_raddr = next_slot;
        page_we    = 1'b0;
        page_waddr = r_cur;
        page_wdata = r_page;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_tuser == OP_ACCESS) begin
                        meta_raddr = SW'(in_slot);
                    end else if (can_place) begin
                        meta_we    = 1'b1;
                        meta_waddr = SW'(r_fill);
                        page_we    = 1'b1;
                        page_waddr = SW'(r_fill);
                        page_wdata = in_page;
                    end else begin
                        meta_raddr = start_hand;
                    end
                end
            end
            S_ACC: begin
                meta_we          = 1'b1;
                meta_wdata.cnt   = meta_cur.cnt;
                meta_wdata.used  = 1'b1;
                meta_wdata.dirty = meta_cur.dirty | r_wr;
            end
            S_SWEEP: begin
                meta_we = 1'b1;
                if (sw_hit) begin
                    page_we = 1'b1;
                end else begin
                    meta_wdata = sweep_meta;
                end
            end
            S_EVICT, S_DONE: ;
            default: ;
        endcase
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_hand    <= '0;
            r_fwd     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            // in S_DONE the output register is handled by the state itself
            if (r_m_valid && m_tready && (r_state != S_DONE)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_page     <= in_page;
                        r_wr       <= in_wr;
                        r_slot     <= in_slot;
                        r_res_page <= '0;
                        r_res_wb   <= 1'b0;
                        if (s_tuser == OP_ACCESS) begin
                            r_cur <= SW'(in_slot);
                            if (slot_ok) begin
                                r_state <= S_ACC;
                            end else begin
                                r_res_act  <= ACT_INVALID;
                                r_res_slot <= in_slot;
                                r_state    <= S_DONE;
                            end
                        end else if (can_place) begin
                            r_fill     <= r_fill + FW'(1);
                            r_hand     <= '0;
                            r_res_act  <= ACT_PLACE;
                            r_res_slot <= 5'(r_fill);
                            r_state    <= S_DONE;
                        end else begin
                            r_cur   <= start_hand;
                            r_step  <= '0;
                            r_pass  <= 1'b0;
                            r_incr  <= 8'd1;
                            r_gap   <= GAP_NONE;
                            r_fwd   <= 1'b0;
                            r_state <= S_SWEEP;
                        end
                    end
                end
                S_ACC: begin
                    r_res_act  <= ACT_ACCESS;
                    r_res_slot <= r_slot;
                    r_state    <= S_DONE;
                end
                S_SWEEP: begin
                    if (sw_hit) begin
                        r_fwd      <= 1'b0;
                        r_res_act  <= ACT_REPLACE;
                        r_res_slot <= 5'(r_cur);
                        r_res_wb   <= meta_cur.dirty;
                        r_hand     <= next_slot;
                        r_state    <= S_EVICT;
                    end else begin
                        r_gap      <= gap_min;
                        r_fwd      <= (next_slot == r_cur);
                        r_fwd_meta <= sweep_meta;
                        r_cur      <= next_slot;
                        if (last_step) begin
                            r_step <= '0;
                            r_pass <= 1'b1;
                            r_incr <= gap_min;
                        end else begin
                            r_step <= r_step + FW'(1);
                        end
                    end
                end
                S_EVICT: begin
                    r_res_page <= page_rdata;
                    r_state    <= S_DONE;
                end
                S_DONE: begin
                    if (!r_m_valid || m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_act   <= r_res_act;
                        r_m_slot  <= r_res_slot;
                        r_m_page  <= r_res_page;
                        r_m_wb    <= r_res_wb;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tuser  = r_m_act;
    assign m_tdata  = {{(DW - PAGE_BITS - 6){1'b0}}, r_m_wb, r_m_page, r_m_slot};

    // ---------------- checks ----------------
    a_sweep_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> ((FW'(r_cur) < r_fill) && (r_step < r_fill)))
        else $error("sweep slot or step outside the resident ring");

    a_fwd_one_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> ((r_fill == FW'(1)) && (r_state == S_SWEEP)))
        else $error("bypass used outside a one-slot sweep");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= FW'(SET_SLOTS)))
        else $error("fill count beyond slot count");

    a_evict_hand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVICT) |-> ((FW'(r_hand) < r_fill) && (r_res_act == ACT_REPLACE)))
        else $error("hand left outside the ring after a replacement");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the n-chance clock page replacer core.
module tb_top
    import ncpr_pkg::*;
();

    localparam int          SLOTS        = 32;
    localparam int          PAGE_W       = 20;
    localparam int          DATA_W       = 32;
    localparam int          RESET_CYCLES = 12;
    localparam int          DRAIN_CYCLES = 80;
    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          PHASE_ITEMS  = 170;
    localparam int          TAIL_ITEMS   = 140;
    localparam int          PLANNED      = 6;
    localparam logic [7:0]  SWEEP_PLAN [PLANNED] = '{8'd3, 8'hFE, 8'd0, 8'd127, 8'h81, 8'd1};
    localparam logic [5:0]  SET_PLAN   [PLANNED] = '{6'd12, 6'd20, 6'd7, 6'd32, 6'd63, 6'd1};

    typedef struct packed {
        logic [1:0]        action;
        logic [4:0]        slot;
        logic [PAGE_W-1:0] evicted;
        logic              writeback;
    } t_outcome;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    // [19:0] page_number, [24:20] slot_index, [25] is_write, zero pad
    logic [DATA_W-1:0] s_tdata  = '0;
    // [0] opcode
    logic              s_tuser  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // [4:0] chosen_slot, [24:5] evicted_page, [25] needs_writeback, zero pad
    logic [DATA_W-1:0] m_tdata;
    // [1:0] action
    logic [1:0]        m_tuser;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [2:0]        paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Predicted replacer state
    logic [PAGE_W-1:0] page_tbl  [SLOTS];
    logic [7:0]        age_tbl   [SLOTS];
    logic              used_tbl  [SLOTS];
    logic              dirty_tbl [SLOTS];
    int unsigned       fill_n  = 0;
    int unsigned       hand_n  = 0;
    logic [7:0]        sweep_lim_r = SWEEP_LIMIT_RST;
    logic [5:0]        set_lim_r   = SET_LIMIT_RST;

    t_outcome          outcome_q [$];
    int unsigned       fail_cnt   = 0;
    int unsigned       cycle_cnt  = 0;
    int unsigned       stall_left = 0;
    bit                idle_en    = 1'b1;

    nchance_clock_page_replacer_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("** nchance_clock_page_replacer_core: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    // Negative setting: magnitude for clean pages, one more for modified ones.
    function automatic int unsigned evict_threshold(int unsigned s);
        if (sweep_lim_r[7]) begin
            return 32'd256 - {24'd0, sweep_lim_r} + {31'd0, dirty_tbl[s]};
        end
        return {24'd0, sweep_lim_r};
    endfunction

    function automatic int unsigned set_capacity();
        int unsigned lim;
        lim = set_lim_r;
        if (lim == 0) begin
            lim = 1;
        end
        if (lim > SLOTS) begin
            lim = SLOTS;
        end
        return lim;
    endfunction

    function automatic void load_slot(int unsigned s, logic [PAGE_W-1:0] page);
        page_tbl[s]  = page;
        age_tbl[s]   = '0;
        used_tbl[s]  = 1'b0;
        dirty_tbl[s] = 1'b0;
    endfunction

    // Two passes at most; the second adds the smallest gap left by the first.
    function automatic int unsigned sweep_for_victim();
        int unsigned ring;
        int unsigned s;
        int unsigned lim;
        longint unsigned cnt;
        longint unsigned gap_min;
        longint unsigned incr;
        ring    = fill_n;
        gap_min = 64'hFFFF_FFFF;
        incr    = 1;
        if (hand_n >= ring) begin
            hand_n = 0;
        end
        for (int pass = 0; pass < 2; pass++) begin
            for (int step = 0; step < ring; step++) begin
                s = hand_n;
                if (used_tbl[s]) begin
                    age_tbl[s]  = '0;
                    used_tbl[s] = 1'b0;
                end else begin
                    cnt = age_tbl[s] + incr;
                    age_tbl[s] = (cnt > 255) ? 8'hFF : cnt[7:0];
                end
                lim = evict_threshold(s);
                cnt = age_tbl[s];
                if (cnt >= lim) begin
                    return s;
                end
                if (lim - cnt < gap_min) begin
                    gap_min = lim - cnt;
                end
                hand_n = (s + 1 >= ring) ? 0 : s + 1;
            end
            incr = gap_min;
        end
        return hand_n;
    endfunction

    function automatic t_outcome apply_item(logic op, logic [PAGE_W-1:0] page,
                                            logic [4:0] slot, logic wr);
        t_outcome    r;
        int unsigned v;
        r      = '0;
        r.slot = slot;
        if (op == OP_ACCESS) begin
            if (slot < fill_n) begin
                used_tbl[slot] = 1'b1;
                if (wr) begin
                    dirty_tbl[slot] = 1'b1;
                end
                r.action = ACT_ACCESS;
            end else begin
                r.action = ACT_INVALID;
            end
        end else if (fill_n < set_capacity()) begin
            v = fill_n;
            load_slot(v, page);
            fill_n   = v + 1;
            hand_n   = 0;
            r.action = ACT_PLACE;
            r.slot   = v[4:0];
        end else begin
            v           = sweep_for_victim();
            r.evicted   = page_tbl[v];
            r.writeback = dirty_tbl[v];
            load_slot(v, page);
            hand_n   = (v + 1 >= fill_n) ? 0 : v + 1;
            r.action = ACT_REPLACE;
            r.slot   = v[4:0];
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- result side

    always @(posedge i_clk) begin
        t_outcome exp_r;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (outcome_q.size() == 0) begin
                $error("unexpected result: action %0d slot %0d", m_tuser, m_tdata[4:0]);
                fail_cnt++;
            end else begin
                exp_r = outcome_q.pop_front();
                if (m_tuser !== exp_r.action) begin
                    $error("action: expected %0d, got %0d", exp_r.action, m_tuser);
                    fail_cnt++;
                end
                if (m_tdata[4:0] !== exp_r.slot) begin
                    $error("chosen_slot: expected %0d, got %0d", exp_r.slot, m_tdata[4:0]);
                    fail_cnt++;
                end
                if (m_tdata[24:5] !== exp_r.evicted) begin
                    $error("evicted_page: expected 0x%05h, got 0x%05h",
                           exp_r.evicted, m_tdata[24:5]);
                    fail_cnt++;
                end
                if (m_tdata[25] !== exp_r.writeback) begin
                    $error("needs_writeback: expected %0d, got %0d",
                           exp_r.writeback, m_tdata[25]);
                    fail_cnt++;
                end
            end
        end
        if (idle_en && stall_left == 0 && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14);
        end
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- drivers

    // Leaves tvalid high after the accepting edge; the next call or hold_input decides.
    task automatic send_item(input logic op, input logic [PAGE_W-1:0] page,
                             input logic [4:0] slot, input logic wr);
        int unsigned gap;
        gap = (idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, wr, slot, page};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        outcome_q.push_back(apply_item(op, page, slot, wr));
    endtask

    task automatic hold_input();
        s_tvalid <= 1'b0;
    endtask

    task automatic settle();
        hold_input();
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_SWEEP_LIMIT) begin
            sweep_lim_r = val;
        end else begin
            set_lim_r = val[5:0];
        end
    endtask

    task automatic send_random_item();
        logic              op;
        logic [PAGE_W-1:0] page;
        logic [4:0]        slot;
        logic              wr;
        op = ($urandom_range(0, 99) < 40) ? OP_FAULT : OP_ACCESS;
        case ($urandom_range(0, 9))
            0: page = '0;
            1: page = '1;
            default: page = PAGE_W'($urandom);
        endcase
        if (fill_n != 0 && $urandom_range(0, 9) != 0) begin
            slot = 5'($urandom_range(0, fill_n - 1));
        end else begin
            slot = 5'($urandom);
        end
        wr = 1'($urandom);
        send_item(op, page, slot, wr);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_access_before_fill();
        send_item(OP_ACCESS, '1, 5'd0, 1'b1);
        send_item(OP_ACCESS, '0, 5'd31, 1'b0);
    endtask

    // set_limit of zero behaves as one
    task automatic test_single_slot_set();
        settle();
        cfg_write(REG_SET_LIMIT, 8'd0);
        send_item(OP_FAULT, '0, 5'd31, 1'b1);
        send_item(OP_ACCESS, 20'h12345, 5'd0, 1'b1);
        send_item(OP_FAULT, '1, 5'd0, 1'b0);
        send_item(OP_ACCESS, '0, 5'd1, 1'b1);
    endtask

    // 63 is clamped to the slot count
    task automatic test_oversized_set_limit();
        settle();
        cfg_write(REG_SET_LIMIT, 8'd63);
        send_item(OP_FAULT, 20'h00001, 5'd0, 1'b0);
        send_item(OP_FAULT, 20'h80000, 5'd0, 1'b0);
        send_item(OP_FAULT, 20'h55555, 5'd0, 1'b0);
    endtask

    // Limit under the fill count: sweeps still cover every resident slot
    task automatic test_lowered_set_limit();
        settle();
        cfg_write(REG_SET_LIMIT, 8'd2);
        send_item(OP_FAULT, 20'hAAAAA, 5'd0, 1'b0);
        settle();
        cfg_write(REG_SWEEP_LIMIT, 8'd0);
        send_item(OP_FAULT, 20'h0F0F0, 5'd0, 1'b0);
    endtask

    task automatic test_sweep_limit_signs();
        settle();
        cfg_write(REG_SWEEP_LIMIT, 8'hFF);
        send_item(OP_ACCESS, '0, 5'd2, 1'b1);
        send_item(OP_ACCESS, '0, 5'd3, 1'b0);
        send_item(OP_FAULT, 20'h11111, 5'd0, 1'b0);
        send_item(OP_FAULT, 20'h22222, 5'd0, 1'b0);
        send_item(OP_FAULT, 20'h33333, 5'd0, 1'b0);
        settle();
        cfg_write(REG_SWEEP_LIMIT, 8'h81);
        send_item(OP_ACCESS, '0, 5'd1, 1'b1);
        send_item(OP_FAULT, 20'h44444, 5'd0, 1'b0);
        settle();
        cfg_write(REG_SWEEP_LIMIT, 8'd127);
        send_item(OP_FAULT, 20'h66666, 5'd0, 1'b0);
        settle();
        cfg_write(REG_SWEEP_LIMIT, 8'h80);
        send_item(OP_FAULT, 20'h77777, 5'd0, 1'b0);
    endtask

    task automatic test_random_phases();
        logic [7:0] sw;
        logic [5:0] sl;
        for (int p = 0; p < PLANNED + 2; p++) begin
            if (p < PLANNED) begin
                sw = SWEEP_PLAN[p];
                sl = SET_PLAN[p];
            end else begin
                // -127 .. 127
                sw = 8'($urandom_range(0, 254) + 129);
                sl = 6'($urandom_range(1, 32));
            end
            settle();
            cfg_write(REG_SWEEP_LIMIT, sw);
            cfg_write(REG_SET_LIMIT, sl);
            repeat (PHASE_ITEMS) send_random_item();
        end
    endtask

    task automatic test_full_rate();
        settle();
        cfg_write(REG_SWEEP_LIMIT, 8'hFD);
        cfg_write(REG_SET_LIMIT, 8'd32);
        idle_en = 1'b0;
        repeat (TAIL_ITEMS) send_random_item();
    endtask

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            page_tbl[s]  = '0;
            age_tbl[s]   = '0;
            used_tbl[s]  = 1'b0;
            dirty_tbl[s] = 1'b0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_access_before_fill();
        test_single_slot_set();
        test_oversized_set_limit();
        test_lowered_set_limit();
        test_sweep_limit_signs();
        test_random_phases();
        test_full_rate();

        hold_input();
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("** nchance_clock_page_replacer_core: PASSED **");
        end else begin
            $display("** nchance_clock_page_replacer_core: FAILED **");
        end
        $finish;
    end

endmodule
